### src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Plain text only; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/swd_pkg.sv
// Shared types, widths and constants of the simplex weight decoder.
// No dependencies; every other source file but assert_macros.svh imports this package.
package swd_pkg;

  localparam int CODE_W     = 64;
  localparam int LEVELS_W   = 23;
  localparam int WEIGHT_W   = 24;
  localparam int FOURTH_W   = 23;
  localparam int SEARCH_W   = 24;
  localparam int BIT_W      = 5;
  localparam int ROOT_W     = 22;
  localparam int H2_W       = 46;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [LEVELS_W-1:0]  LEVELS_RESET = 23'd4258;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS_N = 1'b0;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2^25.
  localparam logic [31:0] RECIP3       = 32'h00AA_AAAB;
  localparam int          RECIP3_SHIFT = 25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_PREP,
    ST_EV_DIV,
    ST_EV_UR,
    ST_EV_H1,
    ST_EV_H2,
    ST_EV_H3L,
    ST_EV_H3H,
    ST_EV_ADD,
    ST_EV_CMP,
    ST_STEP,
    ST_FIN,
    ST_JLIM,
    ST_JLIM2,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
  } apb_req_t;

  // Constant tail of the four-weight offset for m = 6u + r:
  // floor((3r^2 + 2r^3 + 18) / 36).
  function automatic logic [3:0] tail4(input logic [2:0] r);
    logic [3:0] v;
    case (r)
      3'd2:    v = 4'd1;
      3'd3:    v = 4'd2;
      3'd4:    v = 4'd5;
      3'd5:    v = 4'd9;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // Constant tail of the three-weight offset for a = 6u + r:
  // floor((r^2 + 6) / 12).
  function automatic logic [1:0] tail3(input logic [2:0] r);
    logic [1:0] v;
    case (r)
      3'd3:    v = 2'd1;
      3'd4:    v = 2'd1;
      3'd5:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

### src/swd_channels.sv
// Valid/ready channel interfaces for codes in and weight tuples out.
// Depends on swd_pkg for the field widths.
interface swd_code_if import swd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  logic              end_of_batch;

  modport source(output valid, code, end_of_batch, input ready);
  modport sink(input valid, code, end_of_batch, output ready);
endinterface

interface swd_weight_if import swd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight_first;
  logic [WEIGHT_W-1:0] weight_second;
  logic [WEIGHT_W-1:0] weight_third;
  logic [FOURTH_W-1:0] weight_fourth;
  logic                end_of_batch_out;

  modport source(output valid, weight_first, weight_second, weight_third,
                 weight_fourth, end_of_batch_out, input ready);
  modport sink(input valid, weight_first, weight_second, weight_third,
               weight_fourth, end_of_batch_out, output ready);
endinterface

### src/swd_cfg_regs.sv
// Configuration register bank: holds the level count behind the APB port.
// Depends on swd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swd_cfg_regs import swd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  apb_req_t              apb,
  output logic [APB_DATA_W-1:0] prdata,
  output logic [LEVELS_W-1:0]   levels_n
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_levels;

  assign reg_idx   = apb.paddr[APB_ADDR_W-1:2];
  assign wr_levels = apb.psel && apb.penable && apb.pwrite && (reg_idx == REG_LEVELS_N);

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_n <= LEVELS_RESET;
    end else if (wr_levels) begin
      levels_n <= apb.pwdata[LEVELS_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEVELS_N: prdata = APB_DATA_W'(levels_n);
      default:      prdata = '0;
    endcase
  end

  `ASSERT_NEXT(a_levels_written, clk, rst, wr_levels, levels_n == $past(apb.pwdata[LEVELS_W-1:0]), "level count write lost")

endmodule

### src/simplex_weight_decoder_top.sv
// Simplex weight decoder top level: sequencer, shared multiplier and result register.
// Depends on swd_pkg, swd_channels, swd_cfg_regs and assert_macros.svh.
//
//   Channel   | Role          | Payload
//   ----------+---------------+-------------------------------------------------
//   codes     | sink          | code[63:0], end_of_batch
//   weights   | source        | weight_first/second/third[23:0], weight_fourth[22:0],
//             |               | end_of_batch_out
//   APB       | register port | levels_n at byte address 0
//
// Each code runs a four-weight and then a three-weight search through the single 32x32
// multiplier; a three-weight offset steps EV_PREP, EV_DIV, EV_UR, EV_H1, EV_H2, EV_CMP,
// a four-weight offset adds EV_H3L, EV_H3H, EV_ADD; each search walks 24 bit positions.
// Reset sets levels_n to 4258 and needs no clearing pass.
// A finished tuple sits in the output register; the next code is taken while it waits,
// and the sequencer only holds in its last state if the previous tuple is still there.
`include "assert_macros.svh"

module simplex_weight_decoder_top import swd_pkg::*; #(
  parameter int CODE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  swd_code_if.sink              codes,
  swd_weight_if.source          weights
);

  localparam logic [CODE_W-1:0] CODE_MASK = {CODE_W{1'b1}} >> (CODE_W - CODE_BITS);

  apb_req_t apb;
  logic [LEVELS_W-1:0] levels_n;

  st_t st, st_next;

  logic [CODE_W-1:0]   rem;
  logic [CODE_W-1:0]   top_val;
  logic [CODE_W-1:0]   best;
  logic [CODE_W-1:0]   acc;
  logic [CODE_W-1:0]   prod;
  logic [SEARCH_W-1:0] cand;
  logic [SEARCH_W-1:0] x;
  logic [SEARCH_W-1:0] lim;
  logic [BIT_W-1:0]    bit_idx;
  logic [SEARCH_W-1:0] m;
  logic [ROOT_W-1:0]   u;
  logic [2:0]          r;
  logic [H2_W-1:0]     h2;
  logic [LEVELS_W-1:0] np;
  logic [FOURTH_W-1:0] k;
  logic                in_j;
  logic                top_eval;
  logic                eob;
  logic                out_valid;

  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [SEARCH_W-1:0] t;
  logic                t_fits;
  logic [CODE_W-1:0]   diff;
  logic                take_cand;
  logic [ROOT_W-1:0]   u_new;
  logic [SEARCH_W-1:0] six_u;
  logic [2:0]          r_new;
  logic [31:0]         h1_four;
  logic [31:0]         h1_three;
  logic                out_free;
  logic [WEIGHT_W-1:0] j_sh;
  logic [WEIGHT_W-1:0] i_sh;
  logic [WEIGHT_W-1:0] first_w;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;
  assign pready      = 1'b1;

  swd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .apb      (apb),
    .prdata   (prdata),
    .levels_n (levels_n)
  );

  assign codes.ready   = (st == ST_IDLE);
  assign weights.valid = out_valid;
  assign out_free      = !out_valid || weights.ready;

  // Search candidate: the current answer with the bit under test set.
  assign t         = cand | (SEARCH_W'(1) << bit_idx);
  assign t_fits    = (t <= lim);
  assign diff      = top_val - acc;
  assign take_cand = (diff <= rem);

  // Split the offset argument as 6u + r; prod holds (arg/2) * RECIP3 here.
  assign u_new = prod[RECIP3_SHIFT+ROOT_W-1:RECIP3_SHIFT];
  assign six_u = SEARCH_W'({u_new, 2'b00}) + SEARCH_W'({u_new, 1'b0});
  assign r_new = 3'(m - six_u);

  // Horner coefficients: base4 = ((12u + 3 + 6r)u + r + r^2)u + tail4(r),
  // base3 = (3u + r)u + tail3(r).
  assign h1_four  = 32'({u, 3'b000}) + 32'({u, 2'b00}) + 32'd3 +
                    32'({r, 2'b00}) + 32'({r, 1'b0});
  assign h1_three = 32'({u, 1'b0}) + 32'(u) + 32'(r);

  assign j_sh    = cand + WEIGHT_W'(k);
  assign i_sh    = rem[WEIGHT_W-1:0] + j_sh;
  assign first_w = {levels_n, 1'b0} - WEIGHT_W'(2) - i_sh - j_sh - WEIGHT_W'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    mul_a   = '0;
    mul_b   = '0;
    case (st)
      ST_IDLE: begin
        if (codes.valid) st_next = ST_EV_PREP;
      end
      ST_EV_PREP: st_next = ST_EV_DIV;
      ST_EV_DIV: begin
        mul_a   = 32'(m[SEARCH_W-1:1]);
        mul_b   = RECIP3;
        st_next = ST_EV_UR;
      end
      ST_EV_UR: st_next = ST_EV_H1;
      ST_EV_H1: begin
        mul_a   = in_j ? h1_three : h1_four;
        mul_b   = 32'(u);
        st_next = ST_EV_H2;
      end
      ST_EV_H2: st_next = in_j ? ST_EV_CMP : ST_EV_H3L;
      ST_EV_H3L: begin
        mul_a   = h2[31:0];
        mul_b   = 32'(u);
        st_next = ST_EV_H3H;
      end
      ST_EV_H3H: begin
        mul_a   = 32'(h2[H2_W-1:32]);
        mul_b   = 32'(u);
        st_next = ST_EV_ADD;
      end
      ST_EV_ADD: st_next = ST_EV_CMP;
      ST_EV_CMP: begin
        if (top_eval || bit_idx != '0) begin
          st_next = ST_STEP;
        end else begin
          st_next = ST_FIN;
        end
      end
      ST_STEP: begin
        if (t_fits) begin
          st_next = ST_EV_PREP;
        end else if (bit_idx == '0) begin
          st_next = ST_FIN;
        end
      end
      ST_FIN: st_next = in_j ? ST_DONE : ST_JLIM;
      ST_JLIM: begin
        mul_a   = 32'({np, 1'b1});
        mul_b   = RECIP3;
        st_next = ST_JLIM2;
      end
      ST_JLIM2: st_next = ST_EV_PREP;
      ST_DONE: begin
        if (out_free) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (codes.valid) begin
          rem      <= codes.code & CODE_MASK;
          eob      <= codes.end_of_batch;
          in_j     <= 1'b0;
          top_eval <= 1'b1;
          cand     <= '0;
          x        <= '0;
          lim      <= SEARCH_W'(levels_n >> 1);
        end
      end
      ST_EV_PREP: begin
        if (in_j) begin
          m <= SEARCH_W'({np, 1'b1}) - SEARCH_W'({x, 1'b0}) - x;
        end else begin
          m <= SEARCH_W'(levels_n) + SEARCH_W'(1) - SEARCH_W'({x, 1'b0});
        end
      end
      ST_EV_UR: begin
        u <= u_new;
        r <= r_new;
      end
      ST_EV_H2: begin
        if (in_j) begin
          acc <= prod + CODE_W'(tail3(r));
        end else begin
          h2 <= prod[H2_W-1:0] + H2_W'(r) + H2_W'(6'(r) * 6'(r));
        end
      end
      ST_EV_H3H: acc <= prod + CODE_W'(tail4(r));
      ST_EV_ADD: acc <= acc + {prod[31:0], 32'd0};
      ST_EV_CMP: begin
        if (top_eval) begin
          top_val  <= acc;
          best     <= acc;
          top_eval <= 1'b0;
          bit_idx  <= BIT_W'(SEARCH_W - 1);
        end else begin
          if (take_cand) begin
            cand <= x;
            best <= acc;
          end
          if (bit_idx != '0) bit_idx <= bit_idx - BIT_W'(1);
        end
      end
      ST_STEP: begin
        if (t_fits) begin
          x <= t;
        end else if (bit_idx != '0) begin
          bit_idx <= bit_idx - BIT_W'(1);
        end
      end
      ST_FIN: begin
        rem <= rem + best - top_val;
        if (!in_j) begin
          k  <= cand[FOURTH_W-1:0];
          np <= levels_n - {cand[LEVELS_W-2:0], 1'b0};
        end
      end
      ST_JLIM: begin
        in_j     <= 1'b1;
        top_eval <= 1'b1;
        cand     <= '0;
        x        <= '0;
      end
      ST_JLIM2: lim <= SEARCH_W'(prod[RECIP3_SHIFT+SEARCH_W-2:RECIP3_SHIFT]);
      default: ;
    endcase
  end

  // Result register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (weights.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_DONE && out_free) begin
      weights.weight_first     <= first_w;
      weights.weight_second    <= i_sh;
      weights.weight_third     <= j_sh;
      weights.weight_fourth    <= k;
      weights.end_of_batch_out <= eob;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, codes.valid && codes.ready, st != ST_IDLE, "sequencer did not start on an accepted code")
  `ASSERT_IMPLIES(a_cand_in_range, clk, rst, st != ST_IDLE, cand <= lim, "search result beyond its limit")
  `ASSERT_NEXT(a_rem_no_wrap, clk, rst, st == ST_FIN, rem <= $past(rem), "offset subtraction wrapped the remainder")
  `ASSERT_IMPLIES(a_done_holds, clk, rst, st == ST_DONE && out_valid && !weights.ready, st_next == ST_DONE, "result slot overwritten")

endmodule

### sim/swd_decode_checker.sv
// Checker for the simplex weight decoder: watches the register port and both channels.
// Predicts each weight tuple from the transferred code and compares it in order.
// Depends on swd_pkg and the channel interfaces in swd_channels.
module swd_decode_checker import swd_pkg::*; #(
  parameter int CODE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  swd_code_if                   codes,
  swd_weight_if                 weights,
  output int                    errors,
  output int                    pending,
  output logic [CODE_W-1:0]     code_span
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] ADDR_LEVELS = {REG_LEVELS_N, 2'b00};

  typedef struct {
    logic [WEIGHT_W-1:0] first_w;
    logic [WEIGHT_W-1:0] second_w;
    logic [WEIGHT_W-1:0] third_w;
    logic [FOURTH_W-1:0] fourth_w;
    logic                eob;
  } weight_tuple_t;

  logic [LEVELS_W-1:0] levels_n;
  weight_tuple_t       tuples_due[$];

  // Offset of the four-weight layer d for level count n, wrapping modulo 2^64.
  function automatic logic [63:0] offset_four(input logic [63:0] d, input logic [63:0] n);
    logic [63:0] a, q, b;
    a = 64'd2 * d - n - 64'd1;
    q = a * a;
    b = 64'd3 - 64'd2 * a;
    return (q / 64'd36) * b + ((q % 64'd36) * b + 64'd18) / 64'd36;
  endfunction

  // Offset of the three-weight layer c for level count n, rounded to nearest.
  function automatic logic [63:0] offset_three(input logic [63:0] c, input logic [63:0] n);
    logic [63:0] a, q;
    a = 64'd2 * n - 64'd3 * c + 64'd1;
    q = a * a;
    return q / 64'd12 + (((q % 64'd12) >= 64'd6) ? 64'd1 : 64'd0);
  endfunction

  function automatic weight_tuple_t decode_code(input logic [CODE_W-1:0] value,
                                                input logic eob,
                                                input logic [LEVELS_W-1:0] levels);
    logic [63:0] rem, n, np, top4, top3, kmax, jmax, k, j, i, t;
    weight_tuple_t r;
    rem  = value & ({CODE_W{1'b1}} >> (CODE_W - CODE_BITS));
    n    = 64'(levels);
    top4 = offset_four(64'd0, n);
    kmax = n / 64'd2;
    k    = 64'd0;
    // Both searches set one bit at a time, keeping it while the offset still fits.
    for (int b = SEARCH_W - 1; b >= 0; b--) begin
      t = k | (64'd1 << b);
      if (t <= kmax && top4 - offset_four(t, n) <= rem) k = t;
    end
    rem  = rem - (top4 - offset_four(k, n));
    np   = n - 64'd2 * k;
    top3 = offset_three(64'd0, np);
    jmax = (64'd2 * np + 64'd1) / 64'd3;
    j    = 64'd0;
    for (int b = SEARCH_W - 1; b >= 0; b--) begin
      t = j | (64'd1 << b);
      if (t <= jmax && top3 - offset_three(t, np) <= rem) j = t;
    end
    rem = rem - (top3 - offset_three(j, np));
    i   = rem;
    j   = j + k;
    i   = i + j;
    r.first_w  = WEIGHT_W'(64'd2 * (n - 64'd1) - i - j - k);
    r.second_w = WEIGHT_W'(i);
    r.third_w  = WEIGHT_W'(j);
    r.fourth_w = FOURTH_W'(k);
    r.eob      = eob;
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [WEIGHT_W-1:0] want,
                               input logic [WEIGHT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      errors++;
    end
  endtask

  assign code_span = offset_four(64'd0, 64'(levels_n));

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    weight_tuple_t want;
    if (rst) begin
      levels_n <= LEVELS_RESET;
      tuples_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LEVELS)
        levels_n <= pwdata[LEVELS_W-1:0];
      if (codes.valid && codes.ready)
        tuples_due.push_back(decode_code(codes.code, codes.end_of_batch, levels_n));
      if (weights.valid && weights.ready) begin
        if (tuples_due.size() == 0) begin
          $display("%0t: weight transfer with no code outstanding, got %0d %0d %0d %0d %0d",
                   $time, weights.weight_first, weights.weight_second, weights.weight_third,
                   weights.weight_fourth, weights.end_of_batch_out);
          errors++;
        end else begin
          want = tuples_due.pop_front();
          compare_field("weight_first", want.first_w, weights.weight_first);
          compare_field("weight_second", want.second_w, weights.weight_second);
          compare_field("weight_third", want.third_w, weights.weight_third);
          compare_field("weight_fourth", WEIGHT_W'(want.fourth_w),
                        WEIGHT_W'(weights.weight_fourth));
          compare_field("end_of_batch_out", WEIGHT_W'(want.eob),
                        WEIGHT_W'(weights.end_of_batch_out));
        end
      end
    end
    pending <= tuples_due.size();
  end

endmodule

### sim/tb.sv
// Top of the simplex weight decoder testbench: clock, reset, register writes and codes.
// Depends on swd_pkg, swd_channels, the decoder RTL and swd_decode_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swd_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [LEVELS_W-1:0]   LEVELS_MAX    = 23'd6924641;
  localparam logic [APB_ADDR_W-1:0] ADDR_LEVELS   = {REG_LEVELS_N, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic [CODE_W-1:0]     code_span;
  int                    errors;
  int                    pending;
  int                    cycles     = 0;
  int                    stall_left = 0;
  bit                    idle_on    = 1'b0;

  swd_code_if   code_ch();
  swd_weight_if weight_ch();

  simplex_weight_decoder_top #(.CODE_BITS(64)) uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .codes(code_ch), .weights(weight_ch)
  );

  swd_decode_checker #(.CODE_BITS(64)) decode_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .codes(code_ch), .weights(weight_ch), .errors, .pending, .code_span
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The weight side stalls in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      weight_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      weight_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      weight_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      weight_ch.ready <= 1'b1;
    end
  end

  task automatic send_code(input logic [CODE_W-1:0] value, input logic eob);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      code_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_ch.valid        <= 1'b1;
    code_ch.code         <= value;
    code_ch.end_of_batch <= eob;
    do @(posedge clk); while (!code_ch.ready);
  endtask

  task automatic wait_for_results();
    code_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Upper data bits are random; the register only keeps the low 23.
  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [LEVELS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {9'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly valid codes, some right at the end of the valid range, some fully random.
  function automatic logic [CODE_W-1:0] pick_code(input logic [CODE_W-1:0] span);
    logic [CODE_W-1:0] raw;
    int                sel;
    raw = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (span == 0 || sel >= 8) return raw;
    if (sel == 7) return (span > 64'd4) ? span - 64'($urandom_range(0, 4)) : raw;
    return raw % span;
  endfunction

  function automatic logic [LEVELS_W-1:0] phase_levels(input int p);
    case (p)
      0: return 23'd3;
      1: return LEVELS_MAX;
      2: return '0;
      3: return 23'd1;
      4: return '1;
      5: return LEVELS_W'($urandom_range(2, 16));
      6: return LEVELS_W'($urandom_range(2, 300));
      7: return LEVELS_W'($urandom_range(2, LEVELS_MAX));
      8: return LEVELS_W'($urandom_range(17, 64));
      default: return LEVELS_W'($urandom_range(2, 40));
    endcase
  endfunction

  initial begin
    code_ch.valid        = 1'b0;
    code_ch.code         = '0;
    code_ch.end_of_batch = 1'b0;
    weight_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset level count: range ends, invalid codes and alternating bit patterns.
    send_code('0, 1'b0);
    send_code(64'd1, 1'b1);
    send_code(code_span - 64'd1, 1'b0);
    send_code(code_span, 1'b1);
    send_code('1, 1'b0);
    send_code(64'h8000_0000_0000_0000, 1'b1);
    send_code(64'h5555_5555_5555_5555, 1'b0);
    send_code(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

    // A write to an unmapped address must leave the level count alone.
    wait_for_results();
    write_register(ADDR_UNMAPPED, 23'd9);
    send_code(code_span - 64'd1, 1'b0);

    wait_for_results();
    write_register(ADDR_LEVELS, 23'd2);
    send_code('0, 1'b1);
    send_code(64'd1, 1'b0);
    send_code(64'd2, 1'b1);
    send_code('1, 1'b0);

    wait_for_results();
    write_register(ADDR_LEVELS, LEVELS_MAX);
    send_code('0, 1'b0);
    send_code(code_span - 64'd1, 1'b1);
    send_code(code_span, 1'b0);
    send_code('1, 1'b1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_for_results();
      write_register(ADDR_LEVELS, phase_levels(p));
      idle_on = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_code(pick_code(code_span), 1'($urandom_range(0, 1)));
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/swd_pkg.sv
src/swd_channels.sv
src/swd_cfg_regs.sv
src/simplex_weight_decoder_top.sv
sim/swd_decode_checker.sv
sim/tb.sv
